@@ src/shk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes of the shake gesture detector.
package shk_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int MAG_W         = 17;
    localparam int COUNT_W       = 4;
    localparam int THR_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam int ABS_W         = SAMPLE_BITS;
    localparam int PROD_W        = 2 * SAMPLE_BITS;
    localparam int SQ_W          = 2 * SAMPLE_BITS + 2;
    localparam int ROOT_W        = SQ_W / 2;
    localparam int REM_W         = ROOT_W + 3;
    localparam int MUL_STEPS     = 3;
    localparam int SQRT_STEPS    = ROOT_W;
    localparam int STEP_W        = $clog2(SQRT_STEPS);

    localparam logic [MAG_W-1:0]   MAG_MAX       = '1;
    localparam logic [MAG_W-1:0]   LAST_MAG_RST  = MAG_W'(2048);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    localparam logic              ENABLE_RST    = 1'b1;
    localparam logic [THR_W-1:0]  PEAK_RST      = THR_W'(4096);
    localparam logic [THR_W-1:0]  CHANGE_RST    = THR_W'(614);
    localparam logic [THR_W-1:0]  STILL_RST     = THR_W'(102);
    localparam logic [COUNT_W-1:0] REQUIRED_RST = COUNT_W'(3);
    localparam logic [THR_W-1:0]  TIMEOUT_RST   = THR_W'(500);
    localparam logic [THR_W-1:0]  COOLDOWN_RST  = THR_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_PEAK     = 3'd1,
        CFG_CHANGE   = 3'd2,
        CFG_STILL    = 3'd3,
        CFG_REQUIRED = 3'd4,
        CFG_TIMEOUT  = 3'd5,
        CFG_COOLDOWN = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_ROOT,
        S_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [NOW_W-1:0]              now_ms;
    } t_in_item;

    typedef struct packed {
        logic               shake_detected;
        logic               reload_pending;
        logic [COUNT_W-1:0] oscillation_count;
        logic [MAG_W-1:0]   magnitude;
    } t_out_item;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  acc;
        logic  root;
        logic  decide;
        t_axis axis;
    } t_cmd;

    typedef struct packed {
        logic fast;
        logic out_free;
    } t_status;

endpackage

@@ src/shk_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine sequencing squares, root iterations and the decision.
module shk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  shk_pkg::t_status i_status,
    output logic           o_in_stall,
    output shk_pkg::t_cmd  o_cmd
);

    shk_pkg::t_state                 r_state, n_state;
    logic [shk_pkg::STEP_W-1:0]      r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shk_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.axis = shk_pkg::AX_X;
        unique case (r_state)
            shk_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = i_status.fast ? shk_pkg::S_DECIDE : shk_pkg::S_MUL;
                end
            end
            shk_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                unique case (r_step)
                    shk_pkg::STEP_W'(0): o_cmd.axis = shk_pkg::AX_X;
                    shk_pkg::STEP_W'(1): o_cmd.axis = shk_pkg::AX_Y;
                    default:             o_cmd.axis = shk_pkg::AX_Z;
                endcase
                if (r_step == shk_pkg::STEP_W'(shk_pkg::MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = shk_pkg::S_ACC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            shk_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = '0;
                n_state   = shk_pkg::S_ROOT;
            end
            shk_pkg::S_ROOT: begin
                o_cmd.root = 1'b1;
                if (r_step == shk_pkg::STEP_W'(shk_pkg::SQRT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = shk_pkg::S_DECIDE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            shk_pkg::S_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = shk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/shk_dp.sv @@
`timescale 1ns / 1ps
// Datapath: configuration, squaring, iterative square root, gesture state, output register.
module shk_dp #(
    parameter int TIME_BITS = shk_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  shk_pkg::t_in_item               i_in_data,
    input  shk_pkg::t_cmd                   i_cmd,
    output shk_pkg::t_status                o_status,
    input  logic                            i_cfg_valid,
    input  logic [shk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [shk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output shk_pkg::t_out_item              o_out_data
);

    // configuration
    logic                            r_enable;
    logic [shk_pkg::THR_W-1:0]       r_peak, r_change, r_still, r_timeout, r_cooldown;
    logic [shk_pkg::COUNT_W-1:0]     r_required;

    // item and arithmetic
    shk_pkg::t_in_item               r_item;
    logic [shk_pkg::ABS_W-1:0]       r_abs_x, r_abs_y, r_abs_z;
    logic [shk_pkg::PROD_W-1:0]      r_prod;
    logic [shk_pkg::SQ_W-1:0]        r_sum;
    logic [shk_pkg::SQ_W-1:0]        r_rad;
    logic [shk_pkg::REM_W-1:0]       r_rem;
    logic [shk_pkg::ROOT_W-1:0]      r_root;

    // gesture state
    logic [shk_pkg::MAG_W-1:0]       r_last_mag, n_last_mag;
    logic [shk_pkg::COUNT_W-1:0]     r_counter, n_counter;
    logic [TIME_BITS-1:0]            r_trig_time, n_trig_time;
    logic [TIME_BITS-1:0]            r_still_time, n_still_time;
    logic                            r_flag, n_flag;
    logic                            r_trig_valid, n_trig_valid;
    logic                            r_still_valid, n_still_valid;

    logic                            r_out_valid;
    shk_pkg::t_out_item              r_out, n_out;

    logic [shk_pkg::ABS_W-1:0]       mul_in;
    logic [shk_pkg::REM_W-1:0]       rem_shift, trial;
    logic [31:0]                     root_ext;
    logic [shk_pkg::MAG_W-1:0]       mag;
    logic [shk_pkg::MAG_W-1:0]       delta;
    logic [TIME_BITS-1:0]            now_t;
    logic [shk_pkg::COUNT_W-1:0]     cnt_inc;
    logic                            cooling, hit, out_free;

    function automatic logic [shk_pkg::ABS_W-1:0] abs_of(
        input logic [shk_pkg::SAMPLE_BITS-1:0] v
    );
        abs_of = v[shk_pkg::SAMPLE_BITS-1]
                 ? shk_pkg::ABS_W'(~v + shk_pkg::SAMPLE_BITS'(1)) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= shk_pkg::ENABLE_RST;
            r_peak     <= shk_pkg::PEAK_RST;
            r_change   <= shk_pkg::CHANGE_RST;
            r_still    <= shk_pkg::STILL_RST;
            r_required <= shk_pkg::REQUIRED_RST;
            r_timeout  <= shk_pkg::TIMEOUT_RST;
            r_cooldown <= shk_pkg::COOLDOWN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                shk_pkg::CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                shk_pkg::CFG_PEAK:     r_peak     <= i_cfg_data;
                shk_pkg::CFG_CHANGE:   r_change   <= i_cfg_data;
                shk_pkg::CFG_STILL:    r_still    <= i_cfg_data;
                shk_pkg::CFG_REQUIRED: r_required <= i_cfg_data[shk_pkg::COUNT_W-1:0];
                shk_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                shk_pkg::CFG_COOLDOWN: r_cooldown <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.axis)
            shk_pkg::AX_X: mul_in = r_abs_x;
            shk_pkg::AX_Y: mul_in = r_abs_y;
            default:       mul_in = r_abs_z;
        endcase
    end

    assign rem_shift = {r_rem[shk_pkg::REM_W-3:0], r_rad[shk_pkg::SQ_W-1 -: 2]};
    assign trial     = shk_pkg::REM_W'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_abs_x <= abs_of(i_in_data.accel_x);
            r_abs_y <= abs_of(i_in_data.accel_y);
            r_abs_z <= abs_of(i_in_data.accel_z);
            r_prod  <= '0;
            r_sum   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_in * mul_in;
            r_sum  <= r_sum + shk_pkg::SQ_W'(r_prod);
        end
        if (i_cmd.acc) begin
            r_rad  <= r_sum + shk_pkg::SQ_W'(r_prod);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root) begin
            r_rad <= {r_rad[shk_pkg::SQ_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                r_rem  <= rem_shift - trial;
                r_root <= {r_root[shk_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_shift;
                r_root <= {r_root[shk_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root_ext = 32'(r_root);
    assign mag      = (root_ext > 32'(shk_pkg::MAG_MAX))
                      ? shk_pkg::MAG_MAX : root_ext[shk_pkg::MAG_W-1:0];
    assign delta    = (mag >= r_last_mag) ? mag - r_last_mag : r_last_mag - mag;
    assign now_t    = TIME_BITS'(r_item.now_ms);
    assign cooling  = r_trig_valid
                      && ((now_t - r_trig_time) < TIME_BITS'(r_cooldown));
    assign hit      = (delta > shk_pkg::MAG_W'(r_change))
                      && (mag > shk_pkg::MAG_W'(r_peak));
    assign cnt_inc  = (r_counter < shk_pkg::COUNT_MAX) ? r_counter + 1'b1 : r_counter;

    always_comb begin
        n_last_mag    = r_last_mag;
        n_counter     = r_counter;
        n_trig_time   = r_trig_time;
        n_still_time  = r_still_time;
        n_flag        = r_flag;
        n_trig_valid  = r_trig_valid;
        n_still_valid = r_still_valid;
        n_out         = '0;
        if (r_item.op == shk_pkg::OP_READ) begin
            n_flag = 1'b0;
            n_out.reload_pending    = r_flag;
            n_out.oscillation_count = r_counter;
        end else if (!r_enable) begin
            n_counter = '0;
            n_out.reload_pending = r_flag;
        end else begin
            if (!cooling) begin
                if (hit) begin
                    n_counter = cnt_inc;
                    if (cnt_inc >= r_required) begin
                        n_flag               = 1'b1;
                        n_trig_time          = now_t;
                        n_trig_valid         = 1'b1;
                        n_counter            = '0;
                        n_out.shake_detected = 1'b1;
                    end
                end else if (delta < shk_pkg::MAG_W'(r_still)) begin
                    if (r_counter != '0) begin
                        if (!r_still_valid) begin
                            n_still_time  = now_t;
                            n_still_valid = 1'b1;
                        end else if ((now_t - r_still_time) > TIME_BITS'(r_timeout)) begin
                            n_counter     = '0;
                            n_still_valid = 1'b0;
                        end
                    end
                end
                n_last_mag = mag;
            end
            n_out.reload_pending    = n_flag;
            n_out.oscillation_count = n_counter;
            n_out.magnitude         = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mag    <= shk_pkg::LAST_MAG_RST;
            r_counter     <= '0;
            r_trig_time   <= '0;
            r_still_time  <= '0;
            r_flag        <= 1'b0;
            r_trig_valid  <= 1'b0;
            r_still_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_last_mag    <= n_last_mag;
            r_counter     <= n_counter;
            r_trig_time   <= n_trig_time;
            r_still_time  <= n_still_time;
            r_flag        <= n_flag;
            r_trig_valid  <= n_trig_valid;
            r_still_valid <= n_still_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out <= n_out;
        end
    end

    assign o_status.fast     = (i_in_data.op == shk_pkg::OP_READ) || !r_enable;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

`ifndef SYNTHESIS
    a_decide_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> out_free)
        else $error("result written over an untaken transaction");

    a_detect_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && n_out.shake_detected |=> r_counter == '0 && r_flag)
        else $error("trigger did not clear count or latch flag");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && r_item.op == shk_pkg::OP_READ |=> !r_flag)
        else $error("read did not clear reload flag");

    a_detect_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.shake_detected |-> r_out.reload_pending)
        else $error("detection without reload flag");
`endif

endmodule

@@ src/accel_shake_gesture_detector_top.sv @@
`timescale 1ns / 1ps
// Sample op: 3 multiply steps, 1 accumulate and 17 square-root iterations, then the decision,
// which waits until the output register is free.
// Read op or disabled sample: the decision follows the input transaction directly.
// Input stalls while an item is in flight; a held result does not block the next input.
// Synchronous active-low reset returns configuration registers, control state and gesture state to defaults.
module accel_shake_gesture_detector_top #(
    parameter int TIME_BITS = shk_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  shk_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output shk_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [shk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [shk_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    shk_pkg::t_cmd    cmd;
    shk_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    shk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    shk_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
